// File: rtl/ssd_pkg.sv
// Shared types and codes for the sorted set difference block.
`timescale 1ns / 1ps
package ssd_pkg;
    localparam int KEY_W = 128;
    localparam int CNT_OUT_W = 11;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_FETCH       = 2'd2,
        CMD_RESTART     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
        key_t key;
    } cell_ctl_t;
endpackage

// File: rtl/ssd_cell.sv
// One cell of a sorted key chain: ordered insert, shift-down pop and clear.
`timescale 1ns / 1ps
module ssd_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssd_pkg::cell_ctl_t ctl,
    input  ssd_pkg::key_t     prev_key,
    input  logic              prev_valid,
    input  logic              prev_less,
    input  ssd_pkg::key_t     next_key,
    input  logic              next_valid,
    output ssd_pkg::key_t     key,
    output logic              valid,
    output logic              less
);
    ssd_pkg::key_t key_reg, key_next;
    logic valid_reg, valid_next;

    assign less  = !valid_reg || (ctl.key < key_reg);
    assign key   = key_reg;
    assign valid = valid_reg;

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ctl.pop) begin
            key_next   = next_key;
            valid_next = next_valid;
        end else if (ctl.ins && less) begin
            if (prev_less) begin
                key_next   = prev_key;
                valid_next = prev_valid;
            end else begin
                key_next   = ctl.key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end
endmodule

// File: rtl/ssd_chain.sv
// Sorted key store built as a chain of cells, smallest key at the head.
`timescale 1ns / 1ps
module ssd_chain #(
    parameter int DEPTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssd_pkg::cell_ctl_t ctl,
    output ssd_pkg::key_t      head_key,
    output logic               head_valid
);
    ssd_pkg::key_t keys [DEPTH];
    logic valids [DEPTH];
    logic lesses [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ssd_pkg::key_t pk, nk;
        logic pv, pl, nv;
        if (i == 0) begin : g_first
            assign pk = '0;
            assign pv = 1'b0;
            assign pl = 1'b0;
        end else begin : g_mid
            assign pk = keys[i-1];
            assign pv = valids[i-1];
            assign pl = lesses[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign nk = '0;
            assign nv = 1'b0;
        end else begin : g_body
            assign nk = keys[i+1];
            assign nv = valids[i+1];
        end
        ssd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .prev_key   (pk),
            .prev_valid (pv),
            .prev_less  (pl),
            .next_key   (nk),
            .next_valid (nv),
            .key        (keys[i]),
            .valid      (valids[i]),
            .less       (lesses[i])
        );
    end

    assign head_key   = keys[0];
    assign head_valid = valids[0];
endmodule

// File: rtl/sorted_set_difference.sv
// Top level: two sorted key chains merged into a stream of differences.
//
// Input channel s_*: s_tuser carries the command (load first, load second,
// fetch, restart), s_tdata the key. Result channel m_*: one result per fetch.
// Loads insert into a sorted chain of cells; keys can stream in back to back
// while no fetch is in progress. Loads after the first fetch are ignored
// until a restart; a load into a full chain is dropped and raises the overflow flag.
// A fetch pops each pair of equal keys at the chain heads, then emits the
// smaller remaining head, or a done result once both chains are empty.
// The result sits in an output register; while it is stalled, loads and
// restarts are still taken, a further fetch waits for the register to drain.
// Reset (aresetn low, synchronous) empties both chains, clears counts and
// flags and drops any pending result. Restart empties the chains and clears
// counts and flags; a pending result is held until taken.
`timescale 1ns / 1ps
module sorted_set_difference #(
    parameter int DEPTH = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // key_high, key_low
    input  logic [1:0]    s_tuser,   // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // diff_high, diff_low
    output logic [24:0]   m_tuser    // side, done_res, first_only_count,
                                     // second_only_count, overflow
);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CNT_OUT_W_L = ssd_pkg::CNT_OUT_W;

    typedef enum logic {ST_IDLE, ST_MERGE} state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_a_reg, fill_a_next, fill_b_reg, fill_b_next;
    logic [CNT_W-1:0] emit_a_reg, emit_a_next, emit_b_reg, emit_b_next;
    logic sorted_reg, sorted_next, ovf_reg, ovf_next;
    logic m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next;
    logic side_reg, side_next, done_reg, done_next;
    logic [CNT_OUT_W_L-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic ovf_out_reg, ovf_out_next;

    ssd_pkg::cell_ctl_t ctl_a, ctl_b;
    ssd_pkg::key_t head_a, head_b, in_key;
    logic hv_a, hv_b, s_acc, out_free;
    ssd_pkg::cmd_t cmd;
    logic [CNT_W+CNT_OUT_W_L-1:0] ext_a, ext_b;

    assign cmd      = ssd_pkg::cmd_t'(s_tuser);
    assign in_key   = {s_tdata[63:0], s_tdata[127:64]};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    ssd_chain #(.DEPTH(DEPTH)) u_chain_a (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_a),
        .head_key(head_a), .head_valid(hv_a)
    );
    ssd_chain #(.DEPTH(DEPTH)) u_chain_b (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_b),
        .head_key(head_b), .head_valid(hv_b)
    );

    always_comb begin
        state_next   = state_reg;
        fill_a_next  = fill_a_reg;
        fill_b_next  = fill_b_reg;
        emit_a_next  = emit_a_reg;
        emit_b_next  = emit_b_reg;
        sorted_next  = sorted_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        side_next    = side_reg;
        done_next    = done_reg;
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        ovf_out_next = ovf_out_reg;
        ctl_a        = '{ins: 1'b0, pop: 1'b0, clr: 1'b0, key: in_key};
        ctl_b        = '{ins: 1'b0, pop: 1'b0, clr: 1'b0, key: in_key};
        ext_a        = '0;
        ext_b        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (cmd)
                        ssd_pkg::CMD_LOAD_FIRST: begin
                            if (!sorted_reg) begin
                                if (fill_a_reg == CNT_W'(DEPTH)) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    ctl_a.ins   = 1'b1;
                                    fill_a_next = fill_a_reg + 1'b1;
                                end
                            end
                        end
                        ssd_pkg::CMD_LOAD_SECOND: begin
                            if (!sorted_reg) begin
                                if (fill_b_reg == CNT_W'(DEPTH)) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    ctl_b.ins   = 1'b1;
                                    fill_b_next = fill_b_reg + 1'b1;
                                end
                            end
                        end
                        ssd_pkg::CMD_FETCH: begin
                            sorted_next = 1'b1;
                            state_next  = ST_MERGE;
                        end
                        ssd_pkg::CMD_RESTART: begin
                            ctl_a.clr   = 1'b1;
                            ctl_b.clr   = 1'b1;
                            fill_a_next = '0;
                            fill_b_next = '0;
                            emit_a_next = '0;
                            emit_b_next = '0;
                            sorted_next = 1'b0;
                            ovf_next    = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                if (hv_a && hv_b && head_a == head_b) begin
                    ctl_a.pop = 1'b1;
                    ctl_b.pop = 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    side_next    = 1'b0;
                    done_next    = 1'b0;
                    m_data_next  = '0;
                    ovf_out_next = ovf_reg;
                    if (hv_a && (!hv_b || head_a < head_b)) begin
                        ctl_a.pop   = 1'b1;
                        emit_a_next = emit_a_reg + 1'b1;
                        m_data_next = {head_a[63:0], head_a[127:64]};
                    end else if (hv_b) begin
                        ctl_b.pop   = 1'b1;
                        emit_b_next = emit_b_reg + 1'b1;
                        m_data_next = {head_b[63:0], head_b[127:64]};
                        side_next   = 1'b1;
                    end else begin
                        done_next = 1'b1;
                    end
                    ext_a      = {{CNT_OUT_W_L{1'b0}}, emit_a_next};
                    ext_b      = {{CNT_OUT_W_L{1'b0}}, emit_b_next};
                    cnt_a_next = ext_a[CNT_OUT_W_L-1:0];
                    cnt_b_next = ext_b[CNT_OUT_W_L-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        side_reg    <= side_next;
        done_reg    <= done_next;
        cnt_a_reg   <= cnt_a_next;
        cnt_b_reg   <= cnt_b_next;
        ovf_out_reg <= ovf_out_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_a_reg  <= '0;
            fill_b_reg  <= '0;
            emit_a_reg  <= '0;
            emit_b_reg  <= '0;
            sorted_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_a_reg  <= fill_a_next;
            fill_b_reg  <= fill_b_next;
            emit_a_reg  <= emit_a_next;
            emit_b_reg  <= emit_b_next;
            sorted_reg  <= sorted_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {ovf_out_reg, cnt_b_reg, cnt_a_reg, done_reg, side_reg};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_a_reg <= CNT_W'(DEPTH) && fill_b_reg <= CNT_W'(DEPTH))
        else $error("fill beyond depth");
    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_a_reg == '0) |-> !hv_a)
        else $error("head valid in empty chain");
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && done_reg) |-> (m_data_reg == '0 && !side_reg))
        else $error("done result carries a key");
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && cmd == ssd_pkg::CMD_RESTART) |=> (fill_a_reg == '0 && !sorted_reg))
        else $error("restart did not clear state");
endmodule

// File: tb/sorted_set_difference_checker.sv
// Checker: watches both channels, predicts each result and compares it field by field.
`timescale 1ns / 1ps
module sorted_set_difference_checker #(
    parameter int DEPTH = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [24:0]  m_tuser,
    output int           err_count,
    output int           outstanding
);
    typedef struct {
        logic [63:0] diff_high;
        logic [63:0] diff_low;
        logic        side;
        logic        done_res;
        logic [10:0] first_only_count;
        logic [10:0] second_only_count;
        logic        overflow;
    } diff_t;

    ssd_pkg::key_t key_store [2][DEPTH];
    int     fill [2];
    int     cursor [2];
    logic   sorted_flag;
    int     emitted [2];
    logic   overflow_flag;
    diff_t  diff_q [$];

    initial begin
        err_count   = 0;
        outstanding = 0;
    end

    function automatic void clear_sets();
        fill[0] = 0;
        fill[1] = 0;
        cursor[0] = 0;
        cursor[1] = 0;
        emitted[0] = 0;
        emitted[1] = 0;
        sorted_flag = 1'b0;
        overflow_flag = 1'b0;
    endfunction

    function automatic void sort_set(int s);
        ssd_pkg::key_t k;
        int   j;
        for (int i = 1; i < fill[s]; i++) begin
            k = key_store[s][i];
            j = i;
            while (j > 0 && key_store[s][j-1] > k) begin
                key_store[s][j] = key_store[s][j-1];
                j--;
            end
            key_store[s][j] = k;
        end
    endfunction

    function automatic void take_request(ssd_pkg::cmd_t cmd, ssd_pkg::key_t k);
        diff_t d;
        int    pick;
        if (cmd == ssd_pkg::CMD_LOAD_FIRST || cmd == ssd_pkg::CMD_LOAD_SECOND) begin
            pick = (cmd == ssd_pkg::CMD_LOAD_SECOND) ? 1 : 0;
            if (!sorted_flag) begin
                if (fill[pick] >= DEPTH) begin
                    overflow_flag = 1'b1;
                end else begin
                    key_store[pick][fill[pick]] = k;
                    fill[pick]++;
                end
            end
        end else if (cmd == ssd_pkg::CMD_RESTART) begin
            clear_sets();
        end else begin
            if (!sorted_flag) begin
                sort_set(0);
                sort_set(1);
                sorted_flag = 1'b1;
            end
            while (cursor[0] < fill[0] && cursor[1] < fill[1] &&
                   key_store[0][cursor[0]] == key_store[1][cursor[1]]) begin
                cursor[0]++;
                cursor[1]++;
            end
            pick = -1;
            if (cursor[0] < fill[0] && cursor[1] < fill[1])
                pick = (key_store[0][cursor[0]] < key_store[1][cursor[1]]) ? 0 : 1;
            else if (cursor[0] < fill[0])
                pick = 0;
            else if (cursor[1] < fill[1])
                pick = 1;
            d.diff_high = '0;
            d.diff_low  = '0;
            d.side      = 1'b0;
            d.done_res  = 1'b0;
            if (pick < 0) begin
                d.done_res = 1'b1;
            end else begin
                {d.diff_high, d.diff_low} = key_store[pick][cursor[pick]];
                d.side = (pick == 1);
                cursor[pick]++;
                emitted[pick]++;
            end
            d.first_only_count  = emitted[0][10:0];
            d.second_only_count = emitted[1][10:0];
            d.overflow          = overflow_flag;
            diff_q.push_back(d);
        end
    endfunction

    function automatic void check_result(logic [127:0] td, logic [24:0] tu);
        diff_t e;
        if (diff_q.size() == 0) begin
            $error("unexpected result: tdata %h tuser %h", td, tu);
            err_count++;
            return;
        end
        e = diff_q.pop_front();
        if (td[63:0] !== e.diff_high) begin
            $error("diff_high: expected %h actual %h", e.diff_high, td[63:0]);
            err_count++;
        end
        if (td[127:64] !== e.diff_low) begin
            $error("diff_low: expected %h actual %h", e.diff_low, td[127:64]);
            err_count++;
        end
        if (tu[0] !== e.side) begin
            $error("side: expected %0d actual %0d", e.side, tu[0]);
            err_count++;
        end
        if (tu[1] !== e.done_res) begin
            $error("done_res: expected %0d actual %0d", e.done_res, tu[1]);
            err_count++;
        end
        if (tu[12:2] !== e.first_only_count) begin
            $error("first_only_count: expected %0d actual %0d",
                   e.first_only_count, tu[12:2]);
            err_count++;
        end
        if (tu[23:13] !== e.second_only_count) begin
            $error("second_only_count: expected %0d actual %0d",
                   e.second_only_count, tu[23:13]);
            err_count++;
        end
        if (tu[24] !== e.overflow) begin
            $error("overflow: expected %0d actual %0d", e.overflow, tu[24]);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_sets();
            diff_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                take_request(ssd_pkg::cmd_t'(s_tuser), {s_tdata[63:0], s_tdata[127:64]});
        end
        outstanding <= diff_q.size();
    end
endmodule

// File: tb/sorted_set_difference_tb.sv
// Testbench top: drives load, fetch and restart requests and gives the verdict.
`timescale 1ns / 1ps
module sorted_set_difference_tb;
    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 2000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = ssd_pkg::CMD_RESTART;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [24:0]  m_tuser;
    int           err_count;
    int           outstanding;
    int           cycles = 0;
    logic         calm = 1'b0;
    int           stall_left = 0;
    ssd_pkg::key_t pool [8];

    sorted_set_difference #(.DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    sorted_set_difference_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .err_count(err_count), .outstanding(outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic ssd_pkg::key_t random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_set_difference_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left <= idle_length();
            m_tready <= 1'b1;
        end
    end

    // key halves swap: key_high goes to the low bits
    task automatic send(ssd_pkg::cmd_t cmd, ssd_pkg::key_t k);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {k[63:0], k[127:64]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic random_phase(output int items);
        int n1, n2, nf;
        ssd_pkg::key_t k;
        items = 0;
        calm = ($urandom_range(4) == 0);
        for (int i = 0; i < 8; i++) pool[i] = random_key();
        send(ssd_pkg::CMD_RESTART, random_key());
        n1 = $urandom_range(12);
        n2 = $urandom_range(12);
        for (int i = 0; i < n1 + n2; i++) begin
            k = ($urandom_range(1)) ? pool[$urandom_range(7)] : random_key();
            if ($urandom_range(19) == 0)
                send(ssd_pkg::cmd_t'($urandom_range(3)), random_key());
            else if ($urandom_range(n1 + n2 - 1) < n1)
                send(ssd_pkg::CMD_LOAD_FIRST, k);
            else
                send(ssd_pkg::CMD_LOAD_SECOND, k);
            items++;
        end
        nf = n1 + n2 + $urandom_range(3);
        for (int i = 0; i < nf; i++) begin
            if ($urandom_range(9) == 0) begin
                send(ssd_pkg::cmd_t'($urandom_range(1)), random_key());
                items++;
            end
            send(ssd_pkg::CMD_FETCH, random_key());
            items++;
        end
    endtask

    initial begin
        int total;
        int got;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(ssd_pkg::CMD_LOAD_FIRST, '0);
        send(ssd_pkg::CMD_LOAD_FIRST, '1);
        send(ssd_pkg::CMD_LOAD_FIRST, {64'h8000_0000_0000_0000, 64'h0});
        send(ssd_pkg::CMD_LOAD_FIRST, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
        send(ssd_pkg::CMD_LOAD_SECOND, '1);
        send(ssd_pkg::CMD_LOAD_SECOND, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
        send(ssd_pkg::CMD_LOAD_SECOND, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
        send(ssd_pkg::CMD_LOAD_SECOND, {64'h7FFF_FFFF_FFFF_FFFF, 64'h1});
        for (int i = 0; i < 6; i++) send(ssd_pkg::CMD_FETCH, '0);
        send(ssd_pkg::CMD_LOAD_FIRST, 128'h5);
        send(ssd_pkg::CMD_FETCH, '0);
        send(ssd_pkg::CMD_RESTART, '1);
        send(ssd_pkg::CMD_FETCH, '0);
        drain();

        // full first store, then more keys that must be dropped
        send(ssd_pkg::CMD_RESTART, '0);
        calm = 1'b1;
        for (int i = 0; i < DEPTH + 3; i++) send(ssd_pkg::CMD_LOAD_FIRST, random_key());
        send(ssd_pkg::CMD_LOAD_SECOND, random_key());
        for (int i = 0; i < 4; i++) send(ssd_pkg::CMD_FETCH, '0);
        drain();

        total = 0;
        while (total < 550) begin
            random_phase(got);
            total += got;
            if ($urandom_range(3) == 0)
                drain();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (err_count == 0 && outstanding == 0) begin
            $display("sorted_set_difference_tb: done, clean");
        end else begin
            $display("sorted_set_difference_tb: done, errors");
        end
        $finish;
    end
endmodule
